[hw/rtl/wave_mesh_face_normal_assert.svh]
// Assertion macros shared by the wave mesh face normal RTL.
`ifndef WAVE_MESH_FACE_NORMAL_ASSERT_SVH
`define WAVE_MESH_FACE_NORMAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define WMFN_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WMFN_ASSERT(lbl, prop, msg) \
  `WMFN_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define WMFN_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define WMFN_ASSERT(lbl, prop, msg)
`endif
`endif

[hw/rtl/wmfn_pkg.sv]
// Types and constants of the wave mesh face normal block.
`default_nettype none
package wmfn_pkg;

  localparam int unsigned POINT_DEPTH = 1024;
  localparam int unsigned PT_IDX_W    = $clog2(POINT_DEPTH);
  localparam int unsigned ADDR_W      = 3;

  localparam logic [14:0] AMP_RESET = 15'd717;

  // sine polynomial coefficients (Q1.14 argument)
  localparam logic [15:0] SIN_C1 = 16'd2320;
  localparam logic [15:0] SIN_C2 = 16'd21024;
  localparam logic [15:0] SIN_C3 = 16'd51472;

  // iterative unit lengths
  localparam logic [4:0] ROOT_STEPS = 5'd21;
  localparam logic [4:0] DIV_STEPS  = 5'd16;

  typedef enum logic {
    REG_AMPLITUDE = 1'b0
  } wmfn_reg_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SHADE = 1'b1
  } wmfn_op_e;

  typedef struct packed {
    logic                 opcode;
    logic [9:0]           point_index;
    logic signed [15:0]   point_x;
    logic signed [15:0]   point_y;
    logic signed [15:0]   base_z;
    logic [15:0]          phase_turns;
    logic [15:0]          rate_turns;
    logic [9:0]           vertex_a_index;
    logic [9:0]           vertex_b_index;
    logic [9:0]           vertex_c_index;
    logic [31:0]          time_ticks;
  } wmfn_req_t;

  typedef struct packed {
    logic signed [15:0] depth_a;
    logic signed [15:0] depth_b;
    logic signed [15:0] depth_c;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } wmfn_rsp_t;

  typedef struct packed {
    logic [15:0]        rate;
    logic [15:0]        phase;
    logic signed [15:0] base_z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } wmfn_point_t;

  // control into and status out of the root / divide unit
  typedef struct packed {
    logic start;
    logic op_div;
  } wmfn_rd_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wmfn_rd_sts_t;

endpackage
`default_nettype wire

[hw/rtl/wmfn_rootdiv.sv]
// Bit-serial square root and restoring divider sharing one compare/subtract.
`default_nettype none
`include "wave_mesh_face_normal_assert.svh"
module wmfn_rootdiv (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire wmfn_pkg::wmfn_rd_ctrl_t ctrl_i,
  input  wire logic [41:0]           opa_i,   // radicand or dividend
  input  wire logic [20:0]           opb_i,   // divisor
  output wire wmfn_pkg::wmfn_rd_sts_t sts_o,
  output wire logic [20:0]           res_o
);

  logic        busy_q, done_q, op_q;
  logic [4:0]  cnt_q;
  logic [41:0] rem_q;
  logic [42:0] ref_q;
  logic [41:0] bit_q;
  logic [15:0] quo_q;
  logic [42:0] trial;
  logic        ge;

  assign trial = op_q ? ref_q : (ref_q + 43'(bit_q));
  assign ge    = ({1'b0, rem_q} >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op_div;
        cnt_q  <= ctrl_i.op_div ? (wmfn_pkg::DIV_STEPS - 5'd1) : (wmfn_pkg::ROOT_STEPS - 5'd1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= opa_i;
      quo_q <= '0;
      bit_q <= 42'd1 << 40;
      ref_q <= ctrl_i.op_div ? (43'(opb_i) << 15) : '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - trial[41:0];
      end
      if (op_q) begin
        quo_q <= {quo_q[14:0], ge};
        ref_q <= ref_q >> 1;
      end else begin
        ref_q <= ge ? ((ref_q >> 1) + 43'(bit_q)) : (ref_q >> 1);
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign res_o = op_q ? {5'd0, quo_q} : ref_q[20:0];

  `WMFN_ASSERT(a_done_idle, done_q |-> !busy_q, "done raised while still stepping")
  `WMFN_ASSERT(a_start_free, ctrl_i.start |-> !busy_q, "unit started while busy")
  `WMFN_ASSERT(a_done_after_last, (busy_q && cnt_q == 5'd0 && !ctrl_i.start) |=> done_q,
               "last step did not raise done")

endmodule
`default_nettype wire

[hw/rtl/wave_mesh_face_normal.sv]
// Top level of the wave mesh face normal block: point table, sequencer, shared multiplier.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------
//  request  | in        | in_valid_i/in_stall_o | in_req_i  (wmfn_req_t)
//  result   | out       | out_valid_o/out_stall_i | out_rsp_o (wmfn_rsp_t)
//  config   | in        | APB psel/penable    | amplitude at byte 0
//
// A point write request is written to the table at its accepting edge. A shade request
// runs each vertex through the single shared multiplier, then the cross product,
// normalization shifts, squares, the bit-serial square root, the divider per normal
// component and the result load; a degenerate face skips from normalization to the load.
// The next request is taken the cycle after the load.
// Reset clears the sequencer and the amplitude (to 0.7); the point table is not
// cleared. A stalled result holds in the output register while the next request
// is taken.
`default_nettype none
`include "wave_mesh_face_normal_assert.svh"
module wave_mesh_face_normal (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output wire logic                       in_stall_o,
  input  wire wmfn_pkg::wmfn_req_t        in_req_i,
  output wire logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output wire wmfn_pkg::wmfn_rsp_t        out_rsp_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [wmfn_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output wire logic [31:0]                prdata,
  output wire logic                       pready
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_ANG, ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_SIN4, ST_SIN5,
    ST_DEP, ST_CROSS, ST_NORM, ST_SQ, ST_ROOT_GO, ST_ROOT, ST_DIV_GO, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [14:0] amp_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == wmfn_pkg::REG_AMPLITUDE) ? {17'd0, amp_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= wmfn_pkg::AMP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == wmfn_pkg::REG_AMPLITUDE) begin
      amp_q <= pwdata[14:0];
    end
  end

  // request capture
  logic in_acc;
  wmfn_pkg::wmfn_req_t req_q;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // point table: one write port, one registered read port
  wmfn_pkg::wmfn_point_t mem [wmfn_pkg::POINT_DEPTH];
  wmfn_pkg::wmfn_point_t rd_q;
  logic [1:0] k_q;
  logic [wmfn_pkg::PT_IDX_W-1:0] rd_addr;

  always_comb begin
    unique case (k_q)
      2'd0:    rd_addr = req_q.vertex_a_index;
      2'd1:    rd_addr = req_q.vertex_b_index;
      default: rd_addr = req_q.vertex_c_index;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.opcode == wmfn_pkg::OP_WRITE) begin
      mem[in_req_i.point_index] <= '{rate: in_req_i.rate_turns, phase: in_req_i.phase_turns,
                                     base_z: in_req_i.base_z, y: in_req_i.point_y,
                                     x: in_req_i.point_x};
    end
    rd_q <= mem[rd_addr];
  end

  // shared multiplier, product registered
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [49:0] prod_q;
  assign mul_p = mul_a * mul_b;

  // per-triangle working registers
  logic signed [15:0] vx_q [3];
  logic signed [15:0] vy_q [3];
  logic signed [15:0] dep_q [3];
  logic signed [15:0] nrm_q [3];
  logic [33:0]        mag_q [3];
  logic [2:0]         cneg_q;
  logic [14:0]        x_q;
  logic [14:0]        x2_q;
  logic               sneg_q;
  logic [2:0]         j_q;
  logic signed [33:0] acc_q;
  logic [41:0]        sum_q;
  logic [20:0]        len_q;
  logic               degen_q;

  // combinational helpers
  logic [15:0]        sh14;
  logic [15:0]        angle;
  logic [15:0]        t1, t2;
  logic [14:0]        smag;
  logic signed [15:0] sval;
  logic signed [16:0] v1x, v1y, v1z, v2x, v2y, v2z;
  logic signed [31:0] pdep, ddep;
  logic signed [17:0] dsum;
  logic signed [15:0] dsat;
  logic [2:0]         jm;
  logic signed [34:0] cdiff, cabs;
  logic               any_hi, all_lo, all_zero;

  assign sh14  = prod_q[29:14];
  assign angle = rd_q.phase + prod_q[31:16];
  assign t1    = wmfn_pkg::SIN_C2 - sh14;
  assign t2    = wmfn_pkg::SIN_C3 - sh14;
  assign smag  = (sh14 > 16'd32767) ? 15'd32767 : sh14[14:0];
  assign sval  = sneg_q ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

  assign pdep = prod_q[31:0] + 32'sd16384;
  assign ddep = pdep >>> 15;
  assign dsum = 18'(rd_q.base_z) + 18'(ddep);
  assign dsat = (dsum > 18'sd32767) ? 16'sh7FFF :
                (dsum < -18'sd32768) ? 16'sh8000 : dsum[15:0];

  assign v1x = 17'(vx_q[0]) - 17'(vx_q[1]);
  assign v1y = 17'(vy_q[0]) - 17'(vy_q[1]);
  assign v1z = 17'(dep_q[0]) - 17'(dep_q[1]);
  assign v2x = 17'(vx_q[1]) - 17'(vx_q[2]);
  assign v2y = 17'(vy_q[1]) - 17'(vy_q[2]);
  assign v2z = 17'(dep_q[1]) - 17'(dep_q[2]);

  assign jm    = j_q - 3'd1;
  assign cdiff = 35'(acc_q) - 35'($signed(prod_q[33:0]));
  assign cabs  = cdiff[34] ? -cdiff : cdiff;

  assign any_hi   = (mag_q[0][33:20] != '0) || (mag_q[1][33:20] != '0) ||
                    (mag_q[2][33:20] != '0);
  assign all_lo   = (mag_q[0][33:19] == '0) && (mag_q[1][33:19] == '0) &&
                    (mag_q[2][33:19] == '0);
  assign all_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_ANG: begin
        mul_a = 33'(rd_q.rate);
        mul_b = 33'(req_q.time_ticks);
      end
      ST_SIN1: begin
        mul_a = 33'(x_q);
        mul_b = 33'(x_q);
      end
      ST_SIN2: begin
        mul_a = 33'(sh14);
        mul_b = 33'(wmfn_pkg::SIN_C1);
      end
      ST_SIN3: begin
        mul_a = 33'(x2_q);
        mul_b = 33'(t1);
      end
      ST_SIN4: begin
        mul_a = 33'(x_q);
        mul_b = 33'(t2);
      end
      ST_SIN5: begin
        mul_a = 33'(amp_q);
        mul_b = 33'(sval);
      end
      ST_CROSS: begin
        unique case (j_q)
          3'd0: begin mul_a = 33'(v1y); mul_b = 33'(v2z); end
          3'd1: begin mul_a = 33'(v1z); mul_b = 33'(v2y); end
          3'd2: begin mul_a = 33'(v1z); mul_b = 33'(v2x); end
          3'd3: begin mul_a = 33'(v1x); mul_b = 33'(v2z); end
          3'd4: begin mul_a = 33'(v1x); mul_b = 33'(v2y); end
          3'd5: begin mul_a = 33'(v1y); mul_b = 33'(v2x); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SQ: begin
        if (j_q < 3'd3) begin
          mul_a = 33'(mag_q[j_q[1:0]][19:0]);
          mul_b = 33'(mag_q[j_q[1:0]][19:0]);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // root / divide unit
  wmfn_pkg::wmfn_rd_ctrl_t rd_ctrl;
  wmfn_pkg::wmfn_rd_sts_t  rd_sts;
  logic [41:0]             rd_opa;
  logic [20:0]             rd_res;
  logic [16:0]             quo;
  logic [14:0]             nmag;

  assign rd_ctrl.start  = (state_q == ST_ROOT_GO) || (state_q == ST_DIV_GO);
  assign rd_ctrl.op_div = (state_q == ST_DIV_GO);
  // dividend: mag * 2^15 plus half the length, for rounding
  assign rd_opa = (state_q == ST_DIV_GO) ?
                  (42'(mag_q[k_q][19:0]) << 15) + 42'(len_q >> 1) : sum_q;
  assign quo    = 17'(rd_res[15:0]);
  assign nmag   = (quo > 17'd32767) ? 15'd32767 : quo[14:0];

  wmfn_rootdiv u_rootdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rd_ctrl),
    .opa_i  (rd_opa),
    .opb_i  (len_q),
    .sts_o  (rd_sts),
    .res_o  (rd_res)
  );

  // output register
  logic                out_valid_q;
  wmfn_pkg::wmfn_rsp_t out_q;
  logic                out_load;

  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // sequencer: state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          if (in_acc && in_req_i.opcode == wmfn_pkg::OP_SHADE) begin
            state_q <= ST_RD;
          end
        end
        ST_RD:   state_q <= ST_ANG;
        ST_ANG:  state_q <= ST_SIN0;
        ST_SIN0: state_q <= ST_SIN1;
        ST_SIN1: state_q <= ST_SIN2;
        ST_SIN2: state_q <= ST_SIN3;
        ST_SIN3: state_q <= ST_SIN4;
        ST_SIN4: state_q <= ST_SIN5;
        ST_SIN5: state_q <= ST_DEP;
        ST_DEP: begin
          if (k_q == 2'd2) begin
            k_q     <= '0;
            j_q     <= '0;
            state_q <= ST_CROSS;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_RD;
          end
        end
        ST_CROSS: begin
          j_q <= j_q + 3'd1;
          if (j_q == 3'd6) begin
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          j_q <= '0;
          if (all_zero) begin
            state_q <= ST_OUT;
          end else if (!any_hi && !all_lo) begin
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          j_q <= j_q + 3'd1;
          if (j_q == 3'd3) begin
            state_q <= ST_ROOT_GO;
          end
        end
        ST_ROOT_GO: state_q <= ST_ROOT;
        ST_ROOT: begin
          k_q <= '0;
          if (rd_sts.done) begin
            state_q <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: state_q <= ST_DIV;
        ST_DIV: begin
          if (rd_sts.done) begin
            if (k_q == 2'd2) begin
              state_q <= ST_OUT;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_DIV_GO;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[49:0];
    if (in_acc) begin
      req_q <= in_req_i;
    end
    unique case (state_q)
      ST_ANG: begin
        vx_q[k_q] <= rd_q.x;
        vy_q[k_q] <= rd_q.y;
      end
      ST_SIN0: begin
        // fold the angle into the first quadrant, keep the sign
        x_q    <= angle[14] ? (15'd16384 - 15'(angle[13:0])) : 15'(angle[13:0]);
        sneg_q <= angle[15];
      end
      ST_SIN2: x2_q <= sh14[14:0];
      ST_DEP:  dep_q[k_q] <= dsat;
      ST_CROSS: begin
        if (j_q != 3'd0) begin
          if (!jm[0]) begin
            acc_q <= prod_q[33:0];
          end else begin
            mag_q[jm[2:1]]  <= cabs[33:0];
            cneg_q[jm[2:1]] <= cdiff[34];
          end
        end
      end
      ST_NORM: begin
        sum_q   <= '0;
        degen_q <= all_zero;
        if (all_zero) begin
          nrm_q[0] <= '0;
          nrm_q[1] <= '0;
          nrm_q[2] <= '0;
        end else if (any_hi) begin
          mag_q[0] <= mag_q[0] >> 1;
          mag_q[1] <= mag_q[1] >> 1;
          mag_q[2] <= mag_q[2] >> 1;
        end else if (all_lo) begin
          mag_q[0] <= mag_q[0] << 1;
          mag_q[1] <= mag_q[1] << 1;
          mag_q[2] <= mag_q[2] << 1;
        end
      end
      ST_SQ: begin
        if (j_q != 3'd0) begin
          sum_q <= sum_q + 42'(prod_q[39:0]);
        end
      end
      ST_ROOT: begin
        if (rd_sts.done) begin
          len_q <= rd_res;
        end
      end
      ST_DIV: begin
        if (rd_sts.done) begin
          nrm_q[k_q] <= cneg_q[k_q] ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_q <= '{depth_a: dep_q[0], depth_b: dep_q[1], depth_c: dep_q[2],
                     normal_x: nrm_q[0], normal_y: nrm_q[1], normal_z: nrm_q[2],
                     degenerate: degen_q};
        end
      end
      default: begin
      end
    endcase
  end

  `WMFN_ASSERT(a_shade_starts, (in_acc && in_req_i.opcode == wmfn_pkg::OP_SHADE) |=>
               (state_q == ST_RD), "shade request did not start the sequence")
  `WMFN_ASSERT(a_done_in_wait, rd_sts.done |-> (state_q == ST_ROOT || state_q == ST_DIV),
               "root/divide result arrived outside a wait state")
  `WMFN_ASSERT(a_degen_zero, (out_valid_o && out_rsp_o.degenerate) |->
               (out_rsp_o.normal_x == 16'sd0 && out_rsp_o.normal_y == 16'sd0 &&
                out_rsp_o.normal_z == 16'sd0), "degenerate face with nonzero normal")
  `WMFN_ASSERT(a_vertex_range, k_q != 2'd3, "vertex counter out of range")

endmodule
`default_nettype wire
